### hw/rtl/wpc_pkg.sv
package wpc_pkg;

    localparam int SAMPLE_W = 32;
    localparam int TS_W     = 32;
    localparam int MEAN_W   = 32;
    localparam int DEV_W    = 25;   // (sample - mean) / 256, floor
    localparam int SUM_W    = 45;   // running sum, sized for the deepest ring
    localparam int SX_W     = 62;   // Sxx, Syy and |Sxy|
    localparam int SXY_W    = 63;
    localparam int WIDE_W   = 124;  // Sxx * Syy and the divider remainder
    localparam int DIVN_W   = 45;
    localparam int QUO_W    = 45;
    localparam int STEP_W   = 6;
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 64;
    localparam int CORR_W   = 16;
    localparam int PAIR_W   = 7;

    localparam logic [STEP_W-1:0] MEAN_STEPS  = STEP_W'(DIVN_W);
    localparam logic [STEP_W-1:0] RATIO_STEPS = STEP_W'(31);
    localparam logic [3:0]        SQRT_TOP    = 4'd15;
    localparam logic [CORR_W-1:0] CORR_MAX    = 16'h7fff;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_CORR  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef struct packed {
        action_t                     action;
        logic [3:0]                  channel;
        logic [3:0]                  other_channel;
        logic [TS_W-1:0]             timestamp;
        logic signed [SAMPLE_W-1:0]  sample;
    } wpc_req_t;

    typedef struct packed {
        logic signed [CORR_W-1:0] correlation;
        logic [PAIR_W-1:0]        pair_count;
        logic                     computed;
    } wpc_rsp_t;

    typedef struct packed {
        logic              start;
        logic              skip_first_shift;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ADD_CHK,
        ST_ADD_FRD,
        ST_ADD_FDROP,
        ST_ADD_PUSH,
        ST_ADD_ARD,
        ST_ADD_AGE,
        ST_ADD_DSTART,
        ST_ADD_DIV,
        ST_ADD_WB,
        ST_COR_X,
        ST_COR_Y,
        ST_COR_CHK,
        ST_P_RDX,
        ST_P_RDY,
        ST_P_DY,
        ST_P_MXY,
        ST_P_MXX,
        ST_P_MYY,
        ST_P_ACC,
        ST_Z_CHK,
        ST_BM_ISSUE,
        ST_BM_ACC,
        ST_RAT_START,
        ST_RAT_DIV,
        ST_SQ_ISSUE,
        ST_SQ_CMP,
        ST_RESULT
    } state_t;

    function automatic logic signed [DEV_W-1:0] deviation(
        input logic signed [SAMPLE_W-1:0] s,
        input logic signed [MEAN_W-1:0]   m
    );
        logic signed [SAMPLE_W:0] d;
        d = $signed({s[SAMPLE_W-1], s}) - $signed({m[MEAN_W-1], m});
        return d[SAMPLE_W:8];
    endfunction

    function automatic logic [DEV_W-1:0] dev_mag(input logic signed [DEV_W-1:0] d);
        return d[DEV_W-1] ? DEV_W'(-d) : DEV_W'(d);
    endfunction

endpackage

### hw/rtl/windowed_pearson_correlator.sv
// Add: the stall includes the mean divide, is longer when a full ring drops its oldest
// sample first, shorter when the ring held nothing (no divide), shortest when ignored.
// Correlate: the stall grows with the pair count n, is shorter on a zero variance and shorter
// still on an early zero result, plus any wait on the output register. Clear: via ST_CLEAR.
// One transaction in work at a time: the divider, the 32x32 multiplier and the memory port.
// Reset empties every ring, clears sums, means and the ready flag, and sets the window to 1000.
module windowed_pearson_correlator #(
    parameter int NUM_CHANNELS = 16,
    parameter int RING_DEPTH   = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [31:0]       cfg_data,
    input  logic              req_valid,
    output logic              req_stall,
    input  wpc_pkg::wpc_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output wpc_pkg::wpc_rsp_t rsp
);
    import wpc_pkg::*;

    localparam int CH_W   = $clog2(NUM_CHANNELS);
    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int MEM_D  = NUM_CHANNELS * RING_DEPTH;
    localparam int ADDR_W = $clog2(MEM_D);

    state_t state_reg, state_next;

    logic [31:0] window_reg;
    logic        evict_seen_reg;
    wpc_req_t    item_reg;

    logic [PTR_W-1:0]         head_arr [NUM_CHANNELS];
    logic [CNT_W-1:0]         cnt_arr  [NUM_CHANNELS];
    logic signed [SUM_W-1:0]  sum_arr  [NUM_CHANNELS];
    logic signed [MEAN_W-1:0] mean_arr [NUM_CHANNELS];

    logic signed [SAMPLE_W-1:0] sample_mem [MEM_D];
    logic [TS_W-1:0]            time_mem   [MEM_D];
    logic signed [SAMPLE_W-1:0] rd_sample_reg;
    logic [TS_W-1:0]            rd_time_reg;

    logic [PTR_W-1:0]         head_w_reg;
    logic [CNT_W-1:0]         cnt_w_reg;
    logic signed [SUM_W-1:0]  sum_w_reg;
    logic signed [MEAN_W-1:0] mean_w_reg;

    logic [PTR_W-1:0]         xhead_reg, yhead_reg;
    logic [CNT_W-1:0]         xcnt_reg, ycnt_reg, n_reg, i_reg;
    logic signed [MEAN_W-1:0] xmean_reg, ymean_reg;
    logic signed [DEV_W-1:0]  dx_reg, dy_reg;
    logic signed [SXY_W-1:0]  sxy_reg;
    logic [SX_W-1:0]          sxx_reg, syy_reg;
    logic                     sxy_neg_reg;

    logic [SX_W-1:0]   bm_a_reg, bm_b_reg;
    logic [1:0]        k_reg;
    logic              bm_sel_reg;
    logic [WIDE_W-1:0] acc_reg, p_reg;
    logic [30:0]       t_reg;
    logic [15:0]       q_reg;
    logic [3:0]        sq_i_reg;

    wpc_rsp_t res_reg;
    wpc_rsp_t rsp_reg;
    logic     rsp_valid_reg;

    logic              accept;
    logic [CH_W-1:0]   chi, oci, arr_idx;
    logic              ch_ok, oc_ok;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] prod;
    div_req_t          div_req;
    logic [WIDE_W-1:0] div_rem, div_den;
    logic [DIVN_W-1:0] div_num;
    logic              div_done;
    logic [QUO_W-1:0]  div_quo;
    logic              evict_now;
    logic              out_free;
    logic [15:0]       sq_cand;

    function automatic logic [PTR_W-1:0] wrap(input logic [PTR_W:0] a);
        return (a >= (PTR_W+1)'(RING_DEPTH)) ? PTR_W'(a - (PTR_W+1)'(RING_DEPTH))
                                             : PTR_W'(a);
    endfunction

    function automatic logic [ADDR_W-1:0] slot(
        input logic [CH_W-1:0]  c,
        input logic [PTR_W-1:0] h,
        input logic [CNT_W-1:0] p
    );
        logic [PTR_W:0] s;
        s = {1'b0, h} + (PTR_W+1)'(p);
        return ADDR_W'(c) * ADDR_W'(RING_DEPTH) + ADDR_W'(wrap(s));
    endfunction

    assign chi      = CH_W'(item_reg.channel);
    assign oci      = CH_W'(item_reg.other_channel);
    assign ch_ok    = int'(item_reg.channel) < NUM_CHANNELS;
    assign oc_ok    = int'(item_reg.other_channel) < NUM_CHANNELS;
    assign arr_idx  = (state_reg == ST_COR_Y) ? oci : chi;
    assign accept   = req_valid && !req_stall;
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign sq_cand  = q_reg | (16'd1 << sq_i_reg);

    always_comb
    begin
        logic signed [TS_W+1:0] age;
        age = $signed({2'b00, item_reg.timestamp}) - $signed({2'b00, rd_time_reg});
        evict_now = age > $signed({2'b00, window_reg});
    end

    wpc_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    wpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .rem_init (div_rem),
        .num_init (div_num),
        .den      (div_den),
        .done     (div_done),
        .quo      (div_quo)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.action)
                        ACT_ADD:   state_next = ST_ADD_CHK;
                        ACT_CORR:  state_next = ST_COR_X;
                        ACT_CLEAR: state_next = ST_CLEAR;
                        ACT_NONE:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR:      state_next = ST_IDLE;
            ST_ADD_CHK:
            begin
                if (window_reg == '0 || !ch_ok)
                    state_next = ST_IDLE;
                else if (cnt_arr[chi] >= CNT_W'(RING_DEPTH))
                    state_next = ST_ADD_FRD;
                else
                    state_next = ST_ADD_PUSH;
            end
            ST_ADD_FRD:    state_next = ST_ADD_FDROP;
            ST_ADD_FDROP:  state_next = ST_ADD_PUSH;
            ST_ADD_PUSH:   state_next = (cnt_w_reg != '0) ? ST_ADD_ARD : ST_ADD_WB;
            ST_ADD_ARD:    state_next = ST_ADD_AGE;
            ST_ADD_AGE:    state_next = ST_ADD_DSTART;
            ST_ADD_DSTART: state_next = ST_ADD_DIV;
            ST_ADD_DIV:    state_next = div_done ? ST_ADD_WB : ST_ADD_DIV;
            ST_ADD_WB:     state_next = ST_IDLE;
            ST_COR_X:
                state_next = (!evict_seen_reg || !ch_ok || !oc_ok) ? ST_RESULT : ST_COR_Y;
            ST_COR_Y:      state_next = ST_COR_CHK;
            ST_COR_CHK:
                state_next = (xcnt_reg < CNT_W'(2) || ycnt_reg < CNT_W'(2)) ? ST_RESULT
                                                                             : ST_P_RDX;
            ST_P_RDX:      state_next = ST_P_RDY;
            ST_P_RDY:      state_next = ST_P_DY;
            ST_P_DY:       state_next = ST_P_MXY;
            ST_P_MXY:      state_next = ST_P_MXX;
            ST_P_MXX:      state_next = ST_P_MYY;
            ST_P_MYY:      state_next = ST_P_ACC;
            ST_P_ACC:      state_next = (i_reg + CNT_W'(1) == n_reg) ? ST_Z_CHK : ST_P_RDX;
            ST_Z_CHK:
                state_next = (sxx_reg == '0 || syy_reg == '0) ? ST_RESULT : ST_BM_ISSUE;
            ST_BM_ISSUE:   state_next = ST_BM_ACC;
            ST_BM_ACC:
            begin
                if (k_reg == 2'd3 && bm_sel_reg)
                    state_next = ST_RAT_START;
                else
                    state_next = ST_BM_ISSUE;
            end
            ST_RAT_START:  state_next = ST_RAT_DIV;
            ST_RAT_DIV:    state_next = div_done ? ST_SQ_ISSUE : ST_RAT_DIV;
            ST_SQ_ISSUE:   state_next = ST_SQ_CMP;
            ST_SQ_CMP:     state_next = (sq_i_reg == '0) ? ST_RESULT : ST_SQ_ISSUE;
            ST_RESULT:     state_next = out_free ? ST_IDLE : ST_RESULT;
            default:       state_next = ST_IDLE;
        endcase
    end

    // unit controls
    always_comb
    begin
        mem_addr = slot(chi, head_w_reg, '0);
        mem_we   = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        div_req  = '0;
        div_rem  = '0;
        div_num  = '0;
        div_den  = '0;
        unique case (state_reg)
            ST_ADD_PUSH:
            begin
                mem_addr = slot(chi, head_w_reg, cnt_w_reg);
                mem_we   = 1'b1;
            end
            ST_ADD_DSTART:
            begin
                div_req.start = 1'b1;
                div_req.steps = MEAN_STEPS;
                div_num = sum_w_reg[SUM_W-1] ? DIVN_W'(-sum_w_reg) : DIVN_W'(sum_w_reg);
                div_den = WIDE_W'(cnt_w_reg);
            end
            ST_P_RDX:      mem_addr = slot(chi, xhead_reg, i_reg);
            ST_P_RDY:      mem_addr = slot(oci, yhead_reg, i_reg);
            ST_P_MXY:
            begin
                mul_a = MUL_W'(dev_mag(dx_reg));
                mul_b = MUL_W'(dev_mag(dy_reg));
            end
            ST_P_MXX:
            begin
                mul_a = MUL_W'(dev_mag(dx_reg));
                mul_b = MUL_W'(dev_mag(dx_reg));
            end
            ST_P_MYY:
            begin
                mul_a = MUL_W'(dev_mag(dy_reg));
                mul_b = MUL_W'(dev_mag(dy_reg));
            end
            ST_BM_ISSUE:
            begin
                mul_a = k_reg[1] ? MUL_W'(bm_a_reg[SX_W-1:MUL_W]) : bm_a_reg[MUL_W-1:0];
                mul_b = k_reg[0] ? MUL_W'(bm_b_reg[SX_W-1:MUL_W]) : bm_b_reg[MUL_W-1:0];
            end
            ST_RAT_START:
            begin
                div_req.start            = 1'b1;
                div_req.skip_first_shift = 1'b1;
                div_req.steps            = RATIO_STEPS;
                div_rem = acc_reg;
                div_den = p_reg;
            end
            ST_SQ_ISSUE:
            begin
                mul_a = MUL_W'(sq_cand);
                mul_b = MUL_W'(sq_cand);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= 32'd1000;
        else if (cfg_write)
            window_reg <= cfg_data;
    end

    // per-channel state and the ready flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evict_seen_reg <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                head_arr[c] <= '0;
                cnt_arr[c]  <= '0;
                sum_arr[c]  <= '0;
                mean_arr[c] <= '0;
            end
        end
        else if (state_reg == ST_CLEAR)
        begin
            evict_seen_reg <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                head_arr[c] <= '0;
                cnt_arr[c]  <= '0;
                sum_arr[c]  <= '0;
                mean_arr[c] <= '0;
            end
        end
        else
        begin
            if (state_reg == ST_ADD_AGE && evict_now)
                evict_seen_reg <= 1'b1;
            if (state_reg == ST_ADD_WB)
            begin
                head_arr[chi] <= head_w_reg;
                cnt_arr[chi]  <= cnt_w_reg;
                sum_arr[chi]  <= sum_w_reg;
                mean_arr[chi] <= mean_w_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sample_mem[mem_addr] <= item_reg.sample;
            time_mem[mem_addr]   <= item_reg.timestamp;
        end
        rd_sample_reg <= sample_mem[mem_addr];
        rd_time_reg   <= time_mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (state_reg == ST_RESULT && out_free)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        logic [WIDE_W-1:0] pp;
        logic [WIDE_W-1:0] acc_n;
        logic [15:0]       q_n;
        pp    = WIDE_W'(prod);
        acc_n = acc_reg;
        q_n   = q_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    item_reg <= req;
            end
            ST_ADD_CHK:
            begin
                head_w_reg <= head_arr[chi];
                cnt_w_reg  <= cnt_arr[chi];
                sum_w_reg  <= sum_arr[chi];
                mean_w_reg <= mean_arr[chi];
            end
            ST_ADD_FDROP:
            begin
                sum_w_reg  <= sum_w_reg - SUM_W'(rd_sample_reg);
                head_w_reg <= wrap({1'b0, head_w_reg} + (PTR_W+1)'(1));
                cnt_w_reg  <= cnt_w_reg - CNT_W'(1);
            end
            ST_ADD_PUSH:
            begin
                cnt_w_reg <= cnt_w_reg + CNT_W'(1);
                sum_w_reg <= sum_w_reg + SUM_W'(item_reg.sample);
            end
            ST_ADD_AGE:
            begin
                if (evict_now)
                begin
                    sum_w_reg  <= sum_w_reg - SUM_W'(rd_sample_reg);
                    head_w_reg <= wrap({1'b0, head_w_reg} + (PTR_W+1)'(1));
                    cnt_w_reg  <= cnt_w_reg - CNT_W'(1);
                end
            end
            ST_ADD_DIV:
            begin
                if (div_done)
                    mean_w_reg <= sum_w_reg[SUM_W-1] ? -$signed(div_quo[MEAN_W-1:0])
                                                     : $signed(div_quo[MEAN_W-1:0]);
            end
            ST_COR_X:
            begin
                res_reg   <= '0;
                xhead_reg <= head_arr[arr_idx];
                xcnt_reg  <= cnt_arr[arr_idx];
                xmean_reg <= mean_arr[arr_idx];
            end
            ST_COR_Y:
            begin
                yhead_reg <= head_arr[arr_idx];
                ycnt_reg  <= cnt_arr[arr_idx];
                ymean_reg <= mean_arr[arr_idx];
            end
            ST_COR_CHK:
            begin
                n_reg   <= (xcnt_reg < ycnt_reg) ? xcnt_reg : ycnt_reg;
                i_reg   <= '0;
                sxy_reg <= '0;
                sxx_reg <= '0;
                syy_reg <= '0;
            end
            ST_P_RDY: dx_reg <= deviation(rd_sample_reg, xmean_reg);
            ST_P_DY:  dy_reg <= deviation(rd_sample_reg, ymean_reg);
            ST_P_MXX:
            begin
                if (dx_reg[DEV_W-1] ^ dy_reg[DEV_W-1])
                    sxy_reg <= sxy_reg - $signed(SXY_W'(prod));
                else
                    sxy_reg <= sxy_reg + $signed(SXY_W'(prod));
            end
            ST_P_MYY: sxx_reg <= sxx_reg + SX_W'(prod);
            ST_P_ACC:
            begin
                syy_reg <= syy_reg + SX_W'(prod);
                i_reg   <= i_reg + CNT_W'(1);
            end
            ST_Z_CHK:
            begin
                res_reg.pair_count <= PAIR_W'(n_reg);
                res_reg.computed   <= 1'b1;
                sxy_neg_reg        <= sxy_reg[SXY_W-1];
                bm_a_reg           <= sxx_reg;
                bm_b_reg           <= syy_reg;
                k_reg              <= '0;
                bm_sel_reg         <= 1'b0;
                acc_reg            <= '0;
            end
            ST_BM_ACC:
            begin
                // place the partial product by which halves were multiplied
                unique case (k_reg)
                    2'd0:       acc_n = acc_reg + pp;
                    2'd1, 2'd2: acc_n = acc_reg + (pp << MUL_W);
                    2'd3:       acc_n = acc_reg + (pp << (2 * MUL_W));
                endcase
                k_reg <= k_reg + 2'd1;
                if (k_reg == 2'd3 && !bm_sel_reg)
                begin
                    p_reg      <= acc_n;
                    acc_reg    <= '0;
                    bm_sel_reg <= 1'b1;
                    bm_a_reg   <= sxy_reg[SXY_W-1] ? SX_W'(-sxy_reg) : SX_W'(sxy_reg);
                    bm_b_reg   <= sxy_reg[SXY_W-1] ? SX_W'(-sxy_reg) : SX_W'(sxy_reg);
                end
                else
                begin
                    acc_reg <= acc_n;
                end
            end
            ST_RAT_DIV:
            begin
                if (div_done)
                begin
                    t_reg    <= div_quo[30:0];
                    q_reg    <= '0;
                    sq_i_reg <= SQRT_TOP;
                end
            end
            ST_SQ_CMP:
            begin
                if (prod <= PROD_W'(t_reg))
                    q_n = sq_cand;
                q_reg    <= q_n;
                sq_i_reg <= sq_i_reg - 4'd1;
                if (sq_i_reg == '0)
                begin
                    if (sxy_neg_reg)
                        res_reg.correlation <= $signed(-q_n);
                    else if (q_n > CORR_MAX)
                        res_reg.correlation <= $signed(CORR_MAX);
                    else
                        res_reg.correlation <= $signed(q_n);
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                    rsp_reg <= res_reg;
            end
            default:
            begin
                acc_n = acc_reg;
            end
        endcase
    end

    assign req_stall = state_reg != ST_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### hw/rtl/wpc_mul.sv
module wpc_mul (
    input  logic                       clk,
    input  logic [wpc_pkg::MUL_W-1:0]  a,
    input  logic [wpc_pkg::MUL_W-1:0]  b,
    output logic [wpc_pkg::PROD_W-1:0] prod
);
    import wpc_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

### hw/rtl/wpc_div.sv
module wpc_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  wpc_pkg::div_req_t          req,
    input  logic [wpc_pkg::WIDE_W-1:0] rem_init,
    input  logic [wpc_pkg::DIVN_W-1:0] num_init,
    input  logic [wpc_pkg::WIDE_W-1:0] den,
    output logic                       done,
    output logic [wpc_pkg::QUO_W-1:0]  quo
);
    import wpc_pkg::*;

    logic              active_reg;
    logic              done_reg;
    logic              first_reg;
    logic              skip_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [WIDE_W-1:0] rem_reg;
    logic [WIDE_W-1:0] den_reg;
    logic [DIVN_W-1:0] num_reg;
    logic [QUO_W-1:0]  quo_reg;

    logic              shift;
    logic [WIDE_W-1:0] rem_sh;
    logic              ge;

    always_comb
    begin
        shift  = !(first_reg && skip_reg);
        rem_sh = shift ? {rem_reg[WIDE_W-2:0], num_reg[DIVN_W-1]} : rem_reg;
        ge     = rem_sh >= den_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else if (req.start)
        begin
            active_reg <= 1'b1;
            done_reg   <= 1'b0;
        end
        else if (active_reg)
        begin
            active_reg <= cnt_reg != STEP_W'(1);
            done_reg   <= cnt_reg == STEP_W'(1);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg   <= rem_init;
            num_reg   <= num_init;
            den_reg   <= den;
            quo_reg   <= '0;
            cnt_reg   <= req.steps;
            first_reg <= 1'b1;
            skip_reg  <= req.skip_first_shift;
        end
        else if (active_reg)
        begin
            rem_reg   <= ge ? rem_sh - den_reg : rem_sh;
            num_reg   <= shift ? {num_reg[DIVN_W-2:0], 1'b0} : num_reg;
            quo_reg   <= {quo_reg[QUO_W-2:0], ge};
            cnt_reg   <= cnt_reg - STEP_W'(1);
            first_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

### test/tb_windowed_pearson_correlator.sv
module tb_windowed_pearson_correlator;
    timeunit 1ns;
    timeprecision 1ps;

    import wpc_pkg::*;

    localparam int CHANS      = 16;
    localparam int DEPTH      = 64;
    localparam int DRAIN      = 700;
    localparam int WATCHDOG   = 20000;
    localparam int LONG_HOLD  = 400;
    localparam int PHASE_LEN  = 210;
    localparam int EXP_D      = 2048;

    typedef struct {
        wpc_req_t r;
        bit       lit;
    } stim_row_t;

    logic     clk;
    logic     rst_n;
    logic     cfg_write;
    logic     [31:0] cfg_data;
    logic     req_valid;
    logic     req_stall;
    wpc_req_t req;
    logic     rsp_valid;
    logic     rsp_stall;
    wpc_rsp_t rsp;

    // shadow of the correlator state
    int              ring_val [CHANS][DEPTH];
    bit [31:0]       ring_ts  [CHANS][DEPTH];
    int unsigned     ring_hd  [CHANS];
    int unsigned     ring_cnt [CHANS];
    longint          ring_sum [CHANS];
    longint          ring_mean[CHANS];
    bit              ready_flag;
    bit [31:0]       window;

    // expected results, written at exp_wr and checked at exp_rd
    wpc_rsp_t    exp_arr[EXP_D];
    int          exp_wr;
    int          exp_rd;
    bit [31:0]   last_ts[CHANS];
    int          errors;
    int          results;
    int          idle_cycles;
    int          hold_cnt;
    stim_row_t   dir_rows[$];

    windowed_pearson_correlator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    function automatic wpc_req_t mk_req(action_t a, int ch, int oc, bit [31:0] ts, bit [31:0] s);
        wpc_req_t r;
        r.action        = a;
        r.channel       = 4'(ch);
        r.other_channel = 4'(oc);
        r.timestamp     = ts;
        r.sample        = s;
        return r;
    endfunction

    function automatic void drop_oldest(int c);
        ring_sum[c] -= longint'(ring_val[c][ring_hd[c]]);
        ring_hd[c]   = (ring_hd[c] + 1) % DEPTH;
        ring_cnt[c]--;
    endfunction

    function automatic bit [15:0] pearson_q15(longint sxy, longint sxx, longint syy);
        bit [63:0]  mag;
        bit [255:0] num;
        bit [255:0] den;
        bit [255:0] t;
        bit [31:0]  q;
        bit [31:0]  c;
        if (sxx == 0 || syy == 0)
            return 16'd0;
        mag = (sxy < 0) ? 64'(-sxy) : 64'(sxy);
        num = (256'(mag) * 256'(mag)) << 30;
        den = 256'(sxx) * 256'(syy);
        t   = num / den;
        q   = 0;
        for (int b = 15; b >= 0; b--)
        begin
            c = q | (32'd1 << b);
            if (256'(c) * 256'(c) <= t)
                q = c;
        end
        if (sxy < 0)
            return 16'(-q);
        return (q > 32767) ? 16'h7fff : 16'(q);
    endfunction

    // advance the shadow by one transaction; returns 1 when a result is due
    function automatic bit correlator_step(wpc_req_t r, output wpc_rsp_t o);
        int     c;
        int     d;
        int     n;
        longint age;
        longint dx;
        longint dy;
        longint sxy;
        longint sxx;
        longint syy;
        c = r.channel;
        d = r.other_channel;
        o = '0;
        case (r.action)
            ACT_ADD:
            begin
                if (window == 0)
                    return 0;
                if (ring_cnt[c] >= DEPTH)
                    drop_oldest(c);
                n = (ring_hd[c] + ring_cnt[c]) % DEPTH;
                ring_val[c][n] = r.sample;
                ring_ts[c][n]  = r.timestamp;
                ring_cnt[c]++;
                ring_sum[c] += longint'(r.sample);
                if (ring_cnt[c] > 1)
                begin
                    age = longint'(r.timestamp) - longint'(ring_ts[c][ring_hd[c]]);
                    if (age > longint'(window))
                    begin
                        drop_oldest(c);
                        ready_flag = 1;
                    end
                    ring_mean[c] = ring_sum[c] / longint'(ring_cnt[c]);
                end
                return 0;
            end
            ACT_CORR:
            begin
                if (!ready_flag || ring_cnt[c] < 2 || ring_cnt[d] < 2)
                    return 1;
                n   = (ring_cnt[c] < ring_cnt[d]) ? ring_cnt[c] : ring_cnt[d];
                sxy = 0;
                sxx = 0;
                syy = 0;
                for (int i = 0; i < n; i++)
                begin
                    dx = (longint'(ring_val[c][(ring_hd[c] + i) % DEPTH]) - ring_mean[c]) >>> 8;
                    dy = (longint'(ring_val[d][(ring_hd[d] + i) % DEPTH]) - ring_mean[d]) >>> 8;
                    sxy += dx * dy;
                    sxx += dx * dx;
                    syy += dy * dy;
                end
                o.correlation = pearson_q15(sxy, sxx, syy);
                o.pair_count  = 7'(n);
                o.computed    = 1'b1;
                return 1;
            end
            ACT_CLEAR:
            begin
                for (int i = 0; i < CHANS; i++)
                begin
                    ring_hd[i]   = 0;
                    ring_cnt[i]  = 0;
                    ring_sum[i]  = 0;
                    ring_mean[i] = 0;
                end
                ready_flag = 0;
                return 0;
            end
            default:
                return 0;
        endcase
    endfunction

    task automatic send_item(wpc_req_t r, bit lit);
        int       gap;
        wpc_rsp_t o;
        gap = $urandom_range(0, 5);
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        if (correlator_step(r, o))
        begin
            exp_arr[exp_wr % EXP_D] = lit ? wpc_rsp_t'('0) : o;
            exp_wr++;
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        req_valid <= 1'b0;
        wait (exp_rd == exp_wr);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic write_window(bit [31:0] v);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(negedge clk);
        cfg_write <= 1'b0;
        window = v;
    endtask

    task automatic random_item(int idx);
        wpc_req_t  r;
        int        pick;
        int        c;
        int        pat;
        pick = $urandom_range(0, 99);
        c    = $urandom_range(0, CHANS - 1);
        r    = mk_req(ACT_ADD, c, $urandom_range(0, CHANS - 1), 0, 0);
        if (pick < 64)
        begin
            if ($urandom_range(0, 9) < 9)
                last_ts[c] = last_ts[c] + $urandom_range(0, 40);
            else
                last_ts[c] = $urandom;
            r.timestamp = last_ts[c];
            pat = $urandom_range(0, 1 << 20) - (1 << 19);
            if ($urandom_range(0, 3) == 0)
                r.sample = $urandom;
            else
                r.sample = (c[0] ? -pat : pat) * (c % 4 + 1) + $urandom_range(0, 4095);
        end
        else if (pick < 92)
        begin
            r.action = ACT_CORR;
        end
        else if (pick < 95)
        begin
            r.action = ACT_CLEAR;
        end
        else
        begin
            r.action    = ACT_NONE;
            r.timestamp = $urandom;
            r.sample    = $urandom;
        end
        if (pick >= 64 && $urandom_range(0, 1))
            r.timestamp = $urandom;
        send_item(r, 0);
    endtask

    // receive side: hold-off count lives here and is spent at falling edges
    always @(negedge clk)
    begin
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (exp_rd == exp_wr)
            begin
                $display("%0t: unexpected result %p", $time, rsp);
                errors++;
            end
            else
            begin
                wpc_rsp_t e;
                e = exp_arr[exp_rd % EXP_D];
                exp_rd++;
                if (rsp.correlation !== e.correlation)
                begin
                    $display("%0t: correlation expected %0d got %0d", $time,
                             e.correlation, rsp.correlation);
                    errors++;
                end
                if (rsp.pair_count !== e.pair_count)
                begin
                    $display("%0t: pair_count expected %0d got %0d", $time,
                             e.pair_count, rsp.pair_count);
                    errors++;
                end
                if (rsp.computed !== e.computed)
                begin
                    $display("%0t: computed expected %0d got %0d", $time,
                             e.computed, rsp.computed);
                    errors++;
                end
            end
            results++;
            hold_cnt = (results == 40) ? LONG_HOLD : $urandom_range(0, 5);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_write)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        bit [31:0] windows[4];
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_data    = '0;
        req_valid   = 1'b0;
        req         = '0;
        rsp_stall   = 1'b0;
        errors      = 0;
        results     = 0;
        idle_cycles = 0;
        hold_cnt    = 0;
        exp_wr      = 0;
        exp_rd      = 0;
        ready_flag  = 0;
        window      = 32'd1000;
        windows     = '{32'hffff_ffff, 32'd1, 32'd0, 32'd300};
        for (int i = 0; i < CHANS; i++)
        begin
            ring_hd[i]   = 0;
            ring_cnt[i]  = 0;
            ring_sum[i]  = 0;
            ring_mean[i] = 0;
            last_ts[i]   = 0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        dir_rows = '{
            '{mk_req(ACT_CORR,  0,  1, 0, 0), 1},
            '{mk_req(ACT_ADD,   0,  0, 0, 32'h7fff_ffff), 0},
            '{mk_req(ACT_ADD,   1,  0, 0, 32'h8000_0000), 0},
            '{mk_req(ACT_ADD,   0,  0, 10, 0), 0},
            '{mk_req(ACT_ADD,   1,  0, 10, 100), 0},
            '{mk_req(ACT_CORR,  0,  1, 0, 0), 1},
            '{mk_req(ACT_NONE,  5,  9, 32'hffff_ffff, 32'hffff_ffff), 0},
            '{mk_req(ACT_ADD,   0,  0, 2000, 32'h0005_0000), 0},
            '{mk_req(ACT_ADD,   0,  0, 2001, 32'hfffd_0000), 0},
            '{mk_req(ACT_ADD,   1,  0, 2000, 32'h0004_0000), 0},
            '{mk_req(ACT_ADD,   1,  0, 2001, 32'hfff0_0000), 0},
            '{mk_req(ACT_CORR,  0,  1, 0, 0), 0},
            '{mk_req(ACT_CORR,  0,  0, 0, 0), 0},
            '{mk_req(ACT_CORR,  2,  3, 0, 0), 1},
            '{mk_req(ACT_CORR,  0, 15, 0, 0), 1},
            '{mk_req(ACT_ADD,  15,  0, 32'hffff_ffff, 32'hffff_ffff), 0},
            '{mk_req(ACT_ADD,  15,  0, 32'hffff_ffff, 32'h0000_0001), 0},
            '{mk_req(ACT_CORR, 15,  0, 0, 0), 0},
            '{mk_req(ACT_ADD,   2,  0, 0, 7), 0},
            '{mk_req(ACT_ADD,   2,  0, 0, 7), 0},
            '{mk_req(ACT_CORR,  2,  0, 0, 0), 0},
            '{mk_req(ACT_CLEAR, 0,  0, 0, 0), 0},
            '{mk_req(ACT_CORR,  0,  1, 0, 0), 1}
        };
        foreach (dir_rows[i])
            send_item(dir_rows[i].r, dir_rows[i].lit);
        wait_idle();

        // first phase runs on the reset window, then walk the other settings
        write_window(32'd1000);
        for (int p = 0; p < 5; p++)
        begin
            if (p > 0)
            begin
                wait_idle();
                write_window(windows[p - 1]);
            end
            for (int i = 0; i < PHASE_LEN; i++)
            begin
                if (p == 0 && i == 100)
                begin
                    @(negedge clk);
                    req_valid <= 1'b0;
                    wait (exp_rd == exp_wr);
                end
                random_item(i);
            end
        end

        @(negedge clk);
        req_valid <= 1'b0;
        wait (exp_rd == exp_wr);
        repeat (DRAIN) @(posedge clk);
        if (errors == 0 && exp_rd == exp_wr)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
